// ----- src/afc_pkg.sv -----
// ============================================================================
// afc_pkg: shared types and constants of the AABB frustum cull block
// Matrix layout, register indexes, reset values and pipeline control types.
// ============================================================================
package afc_pkg;

    // Fixed point formats: coefficients are Q7.8, coordinates carry 8 fraction bits
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 8;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_COLS    = 4;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = COEF_BITS * NUM_ROWS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Z = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_W = 2'd3;

    // Column indexes inside the matrix store
    localparam int COL_X = 0;
    localparam int COL_Y = 1;
    localparam int COL_Z = 2;
    localparam int COL_W = 3;

    // Identity matrix after reset
    localparam logic [CFG_DATA_BITS-1:0] CLIP_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [CFG_DATA_BITS-1:0] CLIP_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [CFG_DATA_BITS-1:0] CLIP_Z_RESET = 64'h0000_0100_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] CLIP_W_RESET = 64'h0100_0000_0000_0000;

    // Per-corner outside flags, one per frustum plane
    typedef struct packed {
        logic left_pl;
        logic right_pl;
        logic bottom_pl;
        logic top_pl;
        logic near_pl;
        logic far_pl;
    } t_planes;

    // Load enables of the two arithmetic stages inside a column unit
    typedef struct packed {
        logic prod;
        logic sum;
    } t_stage_en;

endpackage

// ----- src/afc_if.sv -----
// ============================================================================
// afc_if: handshake channels of the AABB frustum cull block
// Box input, visible-id output and matrix configuration write channels.
// ============================================================================

// Box item channel
interface afc_in_if #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
);
    logic                         valid;
    logic                         ready;
    logic        [ID_BITS-1:0]    draw_id;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;

    modport source (
        output valid, draw_id, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, draw_id, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

// Visible draw channel
interface afc_out_if #(
    parameter int ID_BITS = 16
);
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] visible_id;
    logic               box_invalid;

    modport source (output valid, visible_id, box_invalid, input ready);
    modport sink   (input valid, visible_id, box_invalid, output ready);
endinterface

// Matrix column write channel
interface afc_cfg_if;
    import afc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/afc_column.sv -----
// ============================================================================
// afc_column: one clip-space column for all eight box corners
// Multiplies min and max of each axis by the column coefficients, then sums
// the per-axis terms plus the w-row bias for every corner. Two register stages.
// ============================================================================
module afc_column #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic signed [COORD_BITS-1:0] i_lo     [afc_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0] i_hi     [afc_pkg::NUM_AXES],
    input  logic [afc_pkg::CFG_DATA_BITS-1:0] i_coef,
    input  afc_pkg::t_stage_en           i_en,
    output logic signed [COORD_BITS+afc_pkg::COEF_BITS+1:0] o_corner [afc_pkg::NUM_CORNERS]
);
    import afc_pkg::*;

    localparam int PROD_BITS = COORD_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    logic signed [COEF_BITS-1:0] w_coef [NUM_ROWS];
    logic signed [PROD_BITS-1:0] r_prod_lo [NUM_AXES];
    logic signed [PROD_BITS-1:0] r_prod_hi [NUM_AXES];
    logic signed [PROD_BITS-1:0] r_bias;
    logic signed [SUM_BITS-1:0]  r_corner [NUM_CORNERS];

    // Split the column into its four row coefficients
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            w_coef[r] = $signed(i_coef[r*COEF_BITS +: COEF_BITS]);
        end
    end

    // Product stage: two products per axis, bias is the w row times 1.0
    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_prod_lo[a] <= PROD_BITS'(i_lo[a]) * PROD_BITS'(w_coef[a]);
                r_prod_hi[a] <= PROD_BITS'(i_hi[a]) * PROD_BITS'(w_coef[a]);
            end
            r_bias <= PROD_BITS'(w_coef[NUM_ROWS-1]) <<< FRAC_BITS;
        end
    end

    // Corner stage: corner bit a picks max on axis a
    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r_corner[c] <= SUM_BITS'(((c & 1) != 0) ? r_prod_hi[0] : r_prod_lo[0])
                             + SUM_BITS'(((c & 2) != 0) ? r_prod_hi[1] : r_prod_lo[1])
                             + SUM_BITS'(((c & 4) != 0) ? r_prod_hi[2] : r_prod_lo[2])
                             + SUM_BITS'(r_bias);
            end
        end
    end

    assign o_corner = r_corner;

endmodule

// ----- src/aabb_frustum_cull.sv -----
// ============================================================================
// aabb_frustum_cull: clip-space frustum culling of axis-aligned boxes
// Pipeline: five register stages (input, product, corner sum, plane test,
// output). Throughput: one box per cycle while the output is not stalled,
// set by a fully pipelined datapath with 24 multipliers; culled boxes give
// no result. Reset (synchronous, active low) empties the pipeline and loads
// the identity matrix; the configuration port is always ready.
// ============================================================================
module aabb_frustum_cull #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afc_in_if.sink    i_in,
    afc_out_if.source o_out,
    afc_cfg_if.sink   i_cfg
);
    import afc_pkg::*;

    localparam int PROD_BITS = COORD_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int TEST_BITS = SUM_BITS + 1;

    // Matrix columns
    logic [CFG_DATA_BITS-1:0] r_col [NUM_COLS];

    // Stage valids and stage load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;
    t_stage_en w_col_en;

    // Stage payloads
    logic        [ID_BITS-1:0]    r_id1, r_id2, r_id3, r_id4, r_id5;
    logic                         r_inv1, r_inv2, r_inv3, r_inv4, r_inv5;
    logic signed [COORD_BITS-1:0] r_lo1 [NUM_AXES];
    logic signed [COORD_BITS-1:0] r_hi1 [NUM_AXES];
    logic signed [COORD_BITS-1:0] n_lo  [NUM_AXES];
    logic signed [COORD_BITS-1:0] n_hi  [NUM_AXES];
    logic                         n_inv;
    logic signed [SUM_BITS-1:0]   w_corner [NUM_COLS][NUM_CORNERS];
    t_planes                      n_planes [NUM_CORNERS];
    t_planes                      r_planes4 [NUM_CORNERS];
    t_planes                      w_all_out;
    logic                         n_emit;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[COL_X] <= CLIP_X_RESET;
            r_col[COL_Y] <= CLIP_Y_RESET;
            r_col[COL_Z] <= CLIP_Z_RESET;
            r_col[COL_W] <= CLIP_W_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_CLIP_X: r_col[COL_X] <= i_cfg.data;
                CFG_CLIP_Y: r_col[COL_Y] <= i_cfg.data;
                CFG_CLIP_Z: r_col[COL_Z] <= i_cfg.data;
                CFG_CLIP_W: r_col[COL_W] <= i_cfg.data;
                default:    r_col[COL_X] <= r_col[COL_X];
            endcase
        end
    end

    // Stall chain: a stage loads when it is empty or its successor moves
    assign w_en5 = !r_v5 || o_out.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_in.ready    = w_en1;
    assign w_col_en.prod = w_en2;
    assign w_col_en.sum  = w_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= n_emit;
        end
    end

    // Input stage: gather bounds and flag inverted boxes
    always_comb begin
        n_lo[0] = i_in.box_min_x;
        n_lo[1] = i_in.box_min_y;
        n_lo[2] = i_in.box_min_z;
        n_hi[0] = i_in.box_max_x;
        n_hi[1] = i_in.box_max_y;
        n_hi[2] = i_in.box_max_z;
        n_inv   = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_inv = n_inv | (n_lo[a] > n_hi[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_id1  <= i_in.draw_id;
            r_inv1 <= n_inv;
            r_lo1  <= n_lo;
            r_hi1  <= n_hi;
        end
    end

    // Id and invalid flag follow the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_id2  <= r_id1;
            r_inv2 <= r_inv1;
        end
        if (w_en3) begin
            r_id3  <= r_id2;
            r_inv3 <= r_inv2;
        end
        if (w_en4) begin
            r_id4  <= r_id3;
            r_inv4 <= r_inv3;
        end
        if (w_en5) begin
            r_id5  <= r_id4;
            r_inv5 <= r_inv4;
        end
    end

    // Product and corner-sum stages, one unit per clip column
    for (genvar k = 0; k < NUM_COLS; k++) begin : g_col
        afc_column #(
            .COORD_BITS (COORD_BITS)
        ) u_col (
            .i_clk    (i_clk),
            .i_lo     (r_lo1),
            .i_hi     (r_hi1),
            .i_coef   (r_col[k]),
            .i_en     (w_col_en),
            .o_corner (w_corner[k])
        );
    end

    // Plane test stage: strict outside tests per corner
    always_comb begin
        logic signed [TEST_BITS-1:0] cx, cy, cz, cw;
        for (int c = 0; c < NUM_CORNERS; c++) begin
            cx = TEST_BITS'(w_corner[COL_X][c]);
            cy = TEST_BITS'(w_corner[COL_Y][c]);
            cz = TEST_BITS'(w_corner[COL_Z][c]);
            cw = TEST_BITS'(w_corner[COL_W][c]);
            n_planes[c].left_pl   = (cx + cw) < 0;
            n_planes[c].right_pl  = (cx - cw) > 0;
            n_planes[c].bottom_pl = (cy + cw) < 0;
            n_planes[c].top_pl    = (cy - cw) > 0;
            n_planes[c].near_pl   = cz < 0;
            n_planes[c].far_pl    = (cz - cw) > 0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_planes4 <= n_planes;
        end
    end

    // Decision: culled when every corner is outside one common plane; inverted boxes are never culled
    always_comb begin
        w_all_out = '1;
        for (int c = 0; c < NUM_CORNERS; c++) begin
            w_all_out = w_all_out & r_planes4[c];
        end
        n_emit = r_v4 && (r_inv4 || !(|w_all_out));
    end

    // Output register
    assign o_out.valid       = r_v5;
    assign o_out.visible_id  = r_id5;
    assign o_out.box_invalid = r_inv5;

endmodule

// ----- src/afc_checker.sv -----
// ============================================================================
// afc_checker: port-level checks of the AABB frustum cull block
// Output handshake holding, reset behavior and backpressure source.
// ============================================================================
module afc_checker #(
    parameter int ID_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ID_BITS-1:0] out_id,
    input logic               out_invalid
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A waiting result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_id) && $stable(out_invalid))
        else $error("result changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    // Input can only stall when a result waits at a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

bind aabb_frustum_cull afc_checker #(
    .ID_BITS (ID_BITS)
) u_afc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .out_id      (o_out.visible_id),
    .out_invalid (o_out.box_invalid)
);

// ----- test/tb.sv -----
// ============================================================================
// tb: self-checking bench for aabb_frustum_cull
// Streams boxes through the culling block under random source gaps and sink
// stalls, predicts each visible draw from its own copy of the clip matrix,
// and checks every result in order. The matrix is reloaded between phases.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int COORD_W   = 24;
    localparam int ID_W      = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));

    // One box item as driven on the input channel
    typedef struct {
        logic        [ID_W-1:0]    id;
        logic signed [COORD_W-1:0] lo [NUM_AXES];
        logic signed [COORD_W-1:0] hi [NUM_AXES];
    } t_box;

    // One visible draw as expected on the output channel
    typedef struct {
        logic [ID_W-1:0] id;
        logic            bad;
    } t_draw;

    logic i_clk;
    logic i_rst_n;

    afc_in_if #(.COORD_BITS(COORD_W), .ID_BITS(ID_W)) box_if ();
    afc_out_if #(.ID_BITS(ID_W))                      vis_if ();
    afc_cfg_if                                        cfg_if ();

    aabb_frustum_cull #(
        .COORD_BITS(COORD_W),
        .ID_BITS   (ID_W)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (box_if),
        .o_out  (vis_if),
        .i_cfg  (cfg_if)
    );

    // Shadow copy of the clip matrix columns
    logic [CFG_DATA_BITS-1:0] clip_x = CLIP_X_RESET;
    logic [CFG_DATA_BITS-1:0] clip_y = CLIP_Y_RESET;
    logic [CFG_DATA_BITS-1:0] clip_z = CLIP_Z_RESET;
    logic [CFG_DATA_BITS-1:0] clip_w = CLIP_W_RESET;

    t_box  pending_boxes [$];
    t_draw expected_draws [$];
    t_box  next_box;
    t_box  seen_box;
    t_draw got_draw;
    t_draw want_draw;

    int    boxes_shown  = 0;
    int    boxes_taken  = 0;
    int    draws_taken  = 0;
    int    draws_seen   = 0;
    int    box_hold     = 0;
    int    draw_stall   = 0;
    bit    box_steady   = 1'b0;
    bit    draw_steady  = 1'b0;
    int    n_errors     = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint coef_at(input logic [CFG_DATA_BITS-1:0] col, input int row);
        logic signed [COEF_BITS-1:0] c;
        c = col[COEF_BITS*row +: COEF_BITS];
        return longint'(c);
    endfunction

    // Row vector (x, y, z, 1) times one column, Q.16 result
    function automatic longint clip_dot(input logic [CFG_DATA_BITS-1:0] col,
                                        input longint px, input longint py, input longint pz);
        return px * coef_at(col, 0) + py * coef_at(col, 1) + pz * coef_at(col, 2)
             + (longint'(1) << FRAC_BITS) * coef_at(col, 3);
    endfunction

    // Returns 1 when the box yields a draw; bad flags min > max on an axis
    function automatic bit box_visible(input t_box b, output bit bad);
        longint lo [NUM_AXES];
        longint hi [NUM_AXES];
        longint px, py, pz, cx, cy, cz, cw;
        bit     all_l, all_r, all_b, all_t, all_n, all_f;
        int     a, c;
        bad   = 1'b0;
        all_l = 1'b1;
        all_r = 1'b1;
        all_b = 1'b1;
        all_t = 1'b1;
        all_n = 1'b1;
        all_f = 1'b1;
        for (a = 0; a < NUM_AXES; a++) begin
            lo[a] = longint'(b.lo[a]);
            hi[a] = longint'(b.hi[a]);
            if (lo[a] > hi[a]) bad = 1'b1;
        end
        if (bad) return 1'b1;
        // a plane culls only if every corner is strictly outside it
        for (c = 0; c < NUM_CORNERS; c++) begin
            px = c[0] ? hi[0] : lo[0];
            py = c[1] ? hi[1] : lo[1];
            pz = c[2] ? hi[2] : lo[2];
            cx = clip_dot(clip_x, px, py, pz);
            cy = clip_dot(clip_y, px, py, pz);
            cz = clip_dot(clip_z, px, py, pz);
            cw = clip_dot(clip_w, px, py, pz);
            all_l &= (cx < -cw);
            all_r &= (cx > cw);
            all_b &= (cy < -cw);
            all_t &= (cy > cw);
            all_n &= (cz < 0);
            all_f &= (cz > cw);
        end
        return !(all_l || all_r || all_b || all_t || all_n || all_f);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_box(input int id, input int x0, input int y0, input int z0,
                            input int x1, input int y1, input int z1);
        t_box b;
        b.id    = id[ID_W-1:0];
        b.lo[0] = x0[COORD_W-1:0];
        b.lo[1] = y0[COORD_W-1:0];
        b.lo[2] = z0[COORD_W-1:0];
        b.hi[0] = x1[COORD_W-1:0];
        b.hi[1] = y1[COORD_W-1:0];
        b.hi[2] = z1[COORD_W-1:0];
        pending_boxes.insert(pending_boxes.size(), b);
    endtask

    // Mostly boxes near the unit cube, some full range, some inverted
    function automatic t_box random_box();
        t_box b;
        int   a, u, v, t;
        b.id = ID_W'($urandom);
        for (a = 0; a < NUM_AXES; a++) begin
            if ($urandom_range(0, 9) == 0) begin
                u = int'(COORD_W'($urandom));
                v = int'(COORD_W'($urandom));
                u = (u << (32 - COORD_W)) >>> (32 - COORD_W);
                v = (v << (32 - COORD_W)) >>> (32 - COORD_W);
            end else begin
                u = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
                v = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            end
            if (u > v) begin
                t = u;
                u = v;
                v = t;
            end
            b.lo[a] = u[COORD_W-1:0];
            b.hi[a] = v[COORD_W-1:0];
        end
        // invert one axis now and then
        if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, NUM_AXES - 1);
            u = int'(b.lo[a]);
            v = int'(b.hi[a]);
            if (u != v) begin
                b.lo[a] = v[COORD_W-1:0];
                b.hi[a] = u[COORD_W-1:0];
            end else if (v != COORD_MIN) begin
                b.hi[a] = b.hi[a] - 1'b1;
            end else begin
                b.lo[a] = b.lo[a] + 1'b1;
            end
        end
        return b;
    endfunction

    task automatic push_random(input int count);
        repeat (count) pending_boxes.insert(pending_boxes.size(), random_box());
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] random_column();
        logic [CFG_DATA_BITS-1:0] col;
        int r;
        for (r = 0; r < NUM_ROWS; r++) begin
            if ($urandom_range(0, 3) == 0)
                col[COEF_BITS*r +: COEF_BITS] = COEF_BITS'($urandom);
            else
                col[COEF_BITS*r +: COEF_BITS] = COEF_BITS'(int'($urandom_range(0, 1023)) - 512);
        end
        return col;
    endfunction

    // Waits until every item is in and every draw is out, then lets the
    // pipeline flush culled boxes
    task automatic wait_drained();
        while (pending_boxes.size() != 0 || boxes_taken != boxes_shown
               || expected_draws.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_column(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_CLIP_X: clip_x = data;
            CFG_CLIP_Y: clip_y = data;
            CFG_CLIP_Z: clip_z = data;
            CFG_CLIP_W: clip_w = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_matrix(input logic [CFG_DATA_BITS-1:0] cx,
                               input logic [CFG_DATA_BITS-1:0] cy,
                               input logic [CFG_DATA_BITS-1:0] cz,
                               input logic [CFG_DATA_BITS-1:0] cw);
        wait_drained();
        write_column(CFG_CLIP_X, cx);
        write_column(CFG_CLIP_Y, cy);
        write_column(CFG_CLIP_Z, cz);
        write_column(CFG_CLIP_W, cw);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Box driver: presents queued items at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            box_if.valid <= 1'b0;
        end else if (boxes_taken == boxes_shown) begin
            if (box_hold > 0) begin
                box_if.valid <= 1'b0;
                box_hold--;
            end else if (pending_boxes.size() != 0) begin
                next_box = pending_boxes.pop_front();
                box_if.valid     <= 1'b1;
                box_if.draw_id   <= next_box.id;
                box_if.box_min_x <= next_box.lo[0];
                box_if.box_min_y <= next_box.lo[1];
                box_if.box_min_z <= next_box.lo[2];
                box_if.box_max_x <= next_box.hi[0];
                box_if.box_max_y <= next_box.hi[1];
                box_if.box_max_z <= next_box.hi[2];
                boxes_shown++;
                if ($urandom_range(0, 31) == 0) box_steady = !box_steady;
                box_hold = box_steady ? 0 : $urandom_range(0, 19);
            end else begin
                box_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Draw sink: may stall after each accepted item
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (draws_seen != draws_taken) begin
            draws_seen = draws_taken;
            if ($urandom_range(0, 31) == 0) draw_steady = !draw_steady;
            draw_stall = draw_steady ? 0 : $urandom_range(0, 19);
        end
        if (draw_stall > 0) begin
            vis_if.ready <= 1'b0;
            draw_stall--;
        end else begin
            vis_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks draws and predicts from accepted boxes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (vis_if.valid && vis_if.ready) begin
                draws_taken++;
                got_draw.id  = vis_if.visible_id;
                got_draw.bad = vis_if.box_invalid;
                if (expected_draws.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected draw id=%h invalid=%b",
                                 $realtime, got_draw.id, got_draw.bad);
                end else begin
                    want_draw = expected_draws.pop_front();
                    if (got_draw.id !== want_draw.id || got_draw.bad !== want_draw.bad) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("%0t: draw expected id=%h invalid=%b, got id=%h invalid=%b",
                                     $realtime, want_draw.id, want_draw.bad,
                                     got_draw.id, got_draw.bad);
                    end
                end
            end
            if (box_if.valid && box_if.ready) begin
                seen_box.id    = box_if.draw_id;
                seen_box.lo[0] = box_if.box_min_x;
                seen_box.lo[1] = box_if.box_min_y;
                seen_box.lo[2] = box_if.box_min_z;
                seen_box.hi[0] = box_if.box_max_x;
                seen_box.hi[1] = box_if.box_max_y;
                seen_box.hi[2] = box_if.box_max_z;
                if (box_visible(seen_box, want_draw.bad)) begin
                    want_draw.id = seen_box.id;
                    expected_draws.insert(expected_draws.size(), want_draw);
                end
                boxes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------------
    initial begin
        #10_000_000;
        $display("aabb_frustum_cull: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Phases
    // ------------------------------------------------------------------------
    initial begin
        box_if.valid     = 1'b0;
        box_if.draw_id   = '0;
        box_if.box_min_x = '0;
        box_if.box_min_y = '0;
        box_if.box_min_z = '0;
        box_if.box_max_x = '0;
        box_if.box_max_y = '0;
        box_if.box_max_z = '0;
        vis_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_CLIP_X;
        cfg_if.data      = '0;
        i_rst_n          = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity matrix: field extremes and each plane
        push_box(16'h0000, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        push_box(16'hFFFF, 0, 0, 0, 0, 0, 0);
        push_box(16'h0001, -3*ONE, 0, ONE/4, -2*ONE, ONE/2, ONE/2);   // left
        push_box(16'h0002, 2*ONE, 0, ONE/4, 3*ONE, ONE/2, ONE/2);     // right
        push_box(16'h0003, 0, -3*ONE, ONE/4, ONE/2, -2*ONE, ONE/2);   // bottom
        push_box(16'h0004, 0, 2*ONE, ONE/4, ONE/2, 3*ONE, ONE/2);     // top
        push_box(16'h0005, 0, 0, -2*ONE, ONE/2, ONE/2, -ONE);         // near
        push_box(16'h0006, 0, 0, 2*ONE, ONE/2, ONE/2, 3*ONE);         // far
        push_box(16'h0007, -ONE, 0, ONE/4, -ONE, ONE/2, ONE/2);       // on left plane
        push_box(16'h0008, 0, 0, ONE, ONE/2, ONE/2, ONE);             // on far plane
        push_box(16'h0009, -ONE-1, 0, ONE/4, -ONE-1, 0, ONE/4);       // one lsb past left
        push_box(16'h000A, -3*ONE, 0, ONE/4, 3*ONE, ONE/2, ONE/2);    // straddles x
        // every corner outside, but no common plane
        push_box(16'h000B, -3*ONE, -3*ONE, 0, 3*ONE, 3*ONE, ONE/2);
        // inverted axes, including one that would otherwise be culled
        push_box(16'h0010, ONE, 0, 0, 0, ONE, ONE);
        push_box(16'h0011, 0, ONE, 0, ONE, 0, ONE);
        push_box(16'h0012, 5*ONE, 0, ONE, 6*ONE, ONE, 0);
        push_box(16'hAAAA, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        push_box(16'h5555, 0, 0, 1, 0, 0, 0);                         // inverted by one lsb
        push_box(16'h8000, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_box(16'h7FFF, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        push_random(250);

        // all-zero matrix: w is zero, strict tests never cull
        load_matrix('0, '0, '0, '0);
        push_box(16'h0100, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        push_random(150);

        // coefficient extremes
        load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_8000_7FFF_8000);
        push_random(150);
        load_matrix(64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                    64'h0000_0000_0000_0000, 64'h8000_8000_8000_8000);
        push_random(150);

        // perspective-like projection: w = z, near plane at z = 1
        load_matrix(64'h0000_0000_0000_0180, 64'h0000_0000_0200_0000,
                    64'hFF00_0100_0000_0000, 64'h0000_0100_0000_0000);
        push_random(300);

        // random matrices
        repeat (5) begin
            load_matrix(random_column(), random_column(), random_column(), random_column());
            push_random(190);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("aabb_frustum_cull: match");
        else
            $display("aabb_frustum_cull: mismatch");
        $finish;
    end

endmodule
